[hdl/mme_pkg.sv]
package mme_pkg;

	localparam int unsigned DIM_DEFAULT = 16;
	localparam int unsigned IDX_W       = 6;
	localparam int unsigned VALUE_W     = 16;
	localparam int unsigned MUL_W       = 2 * VALUE_W;
	localparam int unsigned PRODUCT_W   = 38;

	typedef enum logic [1:0] {
		FN_WRITE_A = 2'd0,
		FN_WRITE_B = 2'd1,
		FN_READ_C  = 2'd2
	} func_t;

	typedef struct packed {
		logic clear;
		logic vld;
		logic last;
	} mac_ctl_t;

endpackage

[hdl/mme_req_if.sv]
interface mme_req_if;
	logic                                 valid;
	logic                                 ready;
	logic [1:0]                           func;
	logic [mme_pkg::IDX_W-1:0]            row;
	logic [mme_pkg::IDX_W-1:0]            col;
	logic signed [mme_pkg::VALUE_W-1:0]   value;

	modport source (output valid, func, row, col, value, input ready);
	modport sink (input valid, func, row, col, value, output ready);
endinterface

[hdl/mme_rsp_if.sv]
interface mme_rsp_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [mme_pkg::PRODUCT_W-1:0] product;

	modport source (output valid, product, input ready);
	modport sink (input valid, product, output ready);
endinterface

[hdl/matrix_multiply_engine_unit.sv]
// Square matrix product engine, DIM x DIM, 16-bit signed elements.
// req channel (valid/ready): func selects write A element, write B
// element or read product element C[row][col] = sum_k A[row][k]*B[k][col].
// Writes give no transfer on rsp; func 3 is dropped.
// A write with row or col >= DIM is ignored.
// A read gives one rsp transfer carrying the exact 38-bit signed sum.
// A read with row or col >= DIM returns zero from the cleared accumulator.
// An in-range read walks DIM element pairs through a single
// multiply-accumulate fed by the A and B memories, one pair per cycle,
// then drains the multiply-accumulate pipeline. One read is in flight at
// a time: req.ready is high only while the engine is idle.
// The result sits in an output register; a stalled rsp holds it while
// the engine goes on accepting writes. A finished read waits for that
// register to empty before the engine returns to idle.
// Reset clears control state, the accumulator and the output register;
// matrix contents are undefined until written.
module matrix_multiply_engine_unit #(
	parameter int unsigned DIM = mme_pkg::DIM_DEFAULT
) (
	input  logic            clk,
	input  logic            arst_n,
	mme_req_if.sink         req,
	mme_rsp_if.source       rsp
);

	localparam int unsigned DEPTH = DIM * DIM;
	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned KW    = $clog2(DIM);
	localparam int unsigned CW    = mme_pkg::IDX_W + 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_DRAIN,
		S_DONE
	} state_t;

	state_t                               state_q;
	logic [KW-1:0]                        k_q;
	logic [AW-1:0]                        a_ptr_q;
	logic [AW-1:0]                        b_ptr_q;
	logic                                 out_valid_q;
	logic signed [mme_pkg::PRODUCT_W-1:0] product_q;

	logic                                 req_xfer;
	logic                                 in_range;
	logic [AW-1:0]                        elem_addr;
	logic [AW-1:0]                        row_base;
	logic                                 we_a, we_b;
	logic                                 out_free;
	mme_pkg::mac_ctl_t                    mac_ctl;
	logic signed [mme_pkg::VALUE_W-1:0]   a_rdata, b_rdata;
	logic signed [mme_pkg::PRODUCT_W-1:0] acc;
	logic                                 mac_done;

	assign req.ready = (state_q == S_IDLE);
	assign req_xfer  = req.valid && req.ready;
	assign in_range  = (CW'(req.row) < CW'(DIM)) && (CW'(req.col) < CW'(DIM));
	assign row_base  = AW'(32'(req.row) * DIM);
	assign elem_addr = row_base + AW'(req.col);

	assign we_a = req_xfer && in_range && (req.func == mme_pkg::FN_WRITE_A);
	assign we_b = req_xfer && in_range && (req.func == mme_pkg::FN_WRITE_B);

	assign mac_ctl.clear = req_xfer && (req.func == mme_pkg::FN_READ_C);
	assign mac_ctl.vld   = (state_q == S_RUN);
	assign mac_ctl.last  = (k_q == KW'(DIM - 1));

	assign out_free = !out_valid_q || rsp.ready;

	mme_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.we_a    (we_a),
		.we_b    (we_b),
		.waddr   (elem_addr),
		.wdata   (req.value),
		.re      (mac_ctl.vld),
		.a_raddr (a_ptr_q),
		.b_raddr (b_ptr_q),
		.a_rdata (a_rdata),
		.b_rdata (b_rdata)
	);

	mme_mac u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (mac_ctl),
		.a_rdata (a_rdata),
		.b_rdata (b_rdata),
		.acc     (acc),
		.done    (mac_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			k_q         <= '0;
			a_ptr_q     <= '0;
			b_ptr_q     <= '0;
			out_valid_q <= 1'b0;
			product_q   <= '0;
		end else begin
			if (out_valid_q && rsp.ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (mac_ctl.clear) begin
						k_q     <= '0;
						a_ptr_q <= row_base;
						b_ptr_q <= AW'(req.col);
						state_q <= in_range ? S_RUN : S_DONE;
					end
				end
				S_RUN: begin
					k_q     <= k_q + KW'(1);
					a_ptr_q <= a_ptr_q + AW'(1);
					b_ptr_q <= b_ptr_q + AW'(DIM);
					if (mac_ctl.last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (mac_done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						product_q   <= acc;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid   = out_valid_q;
	assign rsp.product = product_q;

	a_done_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		mac_done |-> state_q == S_DRAIN)
		else $error("accumulator finished outside drain");

	a_done_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		mac_done |=> state_q == S_DONE)
		else $error("finished sum not taken to output");

	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		mac_ctl.clear |=> acc == '0)
		else $error("accumulator not cleared at read start");

	a_run_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN && $past(state_q) == S_IDLE) |-> k_q == '0)
		else $error("element walk did not start at zero");

endmodule

[hdl/mme_store.sv]
module mme_store #(
	parameter int unsigned DEPTH = mme_pkg::DIM_DEFAULT * mme_pkg::DIM_DEFAULT,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic                                clk,
	input  logic                                we_a,
	input  logic                                we_b,
	input  logic [AW-1:0]                       waddr,
	input  logic signed [mme_pkg::VALUE_W-1:0]  wdata,
	input  logic                                re,
	input  logic [AW-1:0]                       a_raddr,
	input  logic [AW-1:0]                       b_raddr,
	output logic signed [mme_pkg::VALUE_W-1:0]  a_rdata,
	output logic signed [mme_pkg::VALUE_W-1:0]  b_rdata
);

	logic signed [mme_pkg::VALUE_W-1:0] a_mem [DEPTH];
	logic signed [mme_pkg::VALUE_W-1:0] b_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we_a) begin
			a_mem[waddr] <= wdata;
		end
		if (re) begin
			a_rdata <= a_mem[a_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (we_b) begin
			b_mem[waddr] <= wdata;
		end
		if (re) begin
			b_rdata <= b_mem[b_raddr];
		end
	end

endmodule

[hdl/mme_mac.sv]
module mme_mac (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  mme_pkg::mac_ctl_t                    ctl,
	input  logic signed [mme_pkg::VALUE_W-1:0]   a_rdata,
	input  logic signed [mme_pkg::VALUE_W-1:0]   b_rdata,
	output logic signed [mme_pkg::PRODUCT_W-1:0] acc,
	output logic                                 done
);

	logic                                 vld_s1, last_s1;
	logic                                 vld_s2, last_s2;
	logic signed [mme_pkg::MUL_W-1:0]     prod_s2;
	logic signed [mme_pkg::PRODUCT_W-1:0] acc_q;
	logic                                 done_q;

	// s1: memory read data, s2: product, then accumulate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			vld_s2  <= 1'b0;
			last_s2 <= 1'b0;
			acc_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			vld_s1  <= ctl.vld;
			last_s1 <= ctl.vld & ctl.last;
			vld_s2  <= vld_s1;
			last_s2 <= last_s1;
			done_q  <= vld_s2 & last_s2;
			if (ctl.clear) begin
				acc_q <= '0;
			end else if (vld_s2) begin
				acc_q <= acc_q + mme_pkg::PRODUCT_W'(prod_s2);
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= a_rdata * b_rdata;
	end

	assign acc  = acc_q;
	assign done = done_q;

endmodule
